[sv/fsu_pkg.sv]
// ----------------------------------------------------------------------------
// fsu_pkg
// Opcodes, binary32 constants and helper functions of the scalar float unit.
// ----------------------------------------------------------------------------
package fsu_pkg;

  typedef enum logic [3:0] {
    OP_ABS   = 4'd0,
    OP_SIGN  = 4'd1,
    OP_FLOOR = 4'd2,
    OP_CEIL  = 4'd3,
    OP_ROUND = 4'd4,
    OP_TRUNC = 4'd5,
    OP_FRACT = 4'd6,
    OP_SQRT  = 4'd7,
    OP_MIN   = 4'd8,
    OP_MAX   = 4'd9
  } op_e;

  localparam logic [31:0] GEN_NAN      = 32'h7FC0_0000;
  localparam logic [31:0] QUIET_BIT    = 32'h0040_0000;
  localparam logic [31:0] ONE_BITS     = 32'h3F80_0000;
  localparam logic [31:0] NEG_ONE_BITS = 32'hBF80_0000;
  localparam logic [31:0] ZERO_BITS    = 32'h0000_0000;

  localparam int unsigned SQRT_STEPS = 25;
  localparam int unsigned ROOT_W     = 25;
  localparam int unsigned REM_W      = 26;
  localparam int unsigned RAD_W      = 50;
  localparam int unsigned NSTG       = SQRT_STEPS + 4;

  function automatic logic is_nan(input logic [31:0] x);
    return (x[30:23] == 8'hFF) && (x[22:0] != 23'd0);
  endfunction

  function automatic logic flt_lt(input logic [31:0] a, input logic [31:0] b);
    logic lt;
    lt = 1'b0;
    if (is_nan(a) || is_nan(b)) begin
      lt = 1'b0;
    end else if ((a[30:0] == 31'd0) && (b[30:0] == 31'd0)) begin
      lt = 1'b0;
    end else if (a[31] != b[31]) begin
      lt = a[31];
    end else if (!a[31]) begin
      lt = a[30:0] < b[30:0];
    end else begin
      lt = a[30:0] > b[30:0];
    end
    return lt;
  endfunction

  function automatic logic [31:0] sign_of(input logic [31:0] x);
    logic [31:0] r;
    if (is_nan(x) || (x[30:0] == 31'd0)) begin
      r = ZERO_BITS;
    end else begin
      r = x[31] ? NEG_ONE_BITS : ONE_BITS;
    end
    return r;
  endfunction

  function automatic logic [31:0] round_integral(input logic [31:0] x, input op_e kind);
    logic [7:0]  e;
    logic [7:0]  fb;
    logic [31:0] unit;
    logic [31:0] mask;
    logic [31:0] t;
    logic [31:0] r;
    e    = x[30:23];
    fb   = 8'd150 - e;
    unit = 32'd1 << fb;
    mask = unit - 32'd1;
    t    = x & ~mask;
    r    = x;
    if (e == 8'hFF) begin
      r = is_nan(x) ? (x | QUIET_BIT) : x;
    end else if (e >= 8'd150) begin
      r = x;
    end else if (e < 8'd127) begin
      if (x[30:0] == 31'd0) begin
        r = x;
      end else begin
        case (kind)
          OP_FLOOR: r = x[31] ? NEG_ONE_BITS : ZERO_BITS;
          OP_CEIL:  r = x[31] ? 32'h8000_0000 : ONE_BITS;
          OP_ROUND: r = (e == 8'd126) ? {x[31], ONE_BITS[30:0]} : {x[31], 31'd0};
          default:  r = {x[31], 31'd0};
        endcase
      end
    end else if ((x & mask) == 32'd0) begin
      r = x;
    end else begin
      case (kind)
        OP_FLOOR: r = x[31] ? (t + unit) : t;
        OP_CEIL:  r = x[31] ? t : (t + unit);
        OP_ROUND: r = (x + (unit >> 1)) & ~mask;
        default:  r = t;
      endcase
    end
    return r;
  endfunction

  function automatic logic [4:0] lzc24(input logic [23:0] v);
    logic [4:0] n;
    n = 5'd0;
    for (int i = 0; i < 24; i++) begin
      if (v[i]) n = 5'(23 - i);
    end
    return n;
  endfunction

  function automatic logic [5:0] lzc49(input logic [48:0] v);
    logic [5:0] n;
    n = 6'd0;
    for (int i = 0; i < 49; i++) begin
      if (v[i]) n = 6'(48 - i);
    end
    return n;
  endfunction

endpackage

[sv/fsu_sqrt_step.sv]
// ----------------------------------------------------------------------------
// fsu_sqrt_step
// One restoring square-root iteration: brings in two radicand bits, one root bit.
// ----------------------------------------------------------------------------
module fsu_sqrt_step
  import fsu_pkg::*;
(
  input  logic [1:0]        pair_i,
  input  logic [ROOT_W-1:0] root_i,
  input  logic [REM_W-1:0]  rem_i,
  output logic [ROOT_W-1:0] root_o,
  output logic [REM_W-1:0]  rem_o
);

  logic [REM_W+1:0] rem_sh;
  logic [REM_W+1:0] trial;
  logic [REM_W+1:0] diff;
  logic             ge;

  assign rem_sh = {rem_i, pair_i};
  assign trial  = {1'b0, root_i, 2'b01};
  assign diff   = rem_sh - trial;
  assign ge     = rem_sh >= trial;
  assign root_o = {root_i[ROOT_W-2:0], ge};
  assign rem_o  = ge ? diff[REM_W-1:0] : rem_sh[REM_W-1:0];

endmodule

[sv/float32_scalar_unit.sv]
// ----------------------------------------------------------------------------
// float32_scalar_unit
// Single-precision scalar function unit: abs, sign, roundings, fract, sqrt, min, max.
// ----------------------------------------------------------------------------
// usage:
//   input channel in_valid_i/in_ready_o carries mode_i, operand_a_i, operand_b_i;
//   output channel out_valid_o/out_ready_i carries result_bits_o, one per input.
//   every opcode runs through the same 29 register stages: decode and simple
//   ops, pre-normalize, fract rounding, 25 square-root iterations (one root bit
//   per stage) and a final rounding stage that is also the output register.
//   one transaction is accepted every cycle while the receiver takes results.
//   when out_valid_o is high and out_ready_i low the whole pipeline holds and
//   in_ready_o drops; nothing is lost or repeated, and the pipeline resumes on
//   the cycle the result is taken.
//   reset clears all valid bits; the pipeline is empty and ready right after.
// ----------------------------------------------------------------------------
module float32_scalar_unit
  import fsu_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [3:0]  mode_i,
  input  logic [31:0] operand_a_i,
  input  logic [31:0] operand_b_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] result_bits_o
);

  typedef struct packed {
    logic              sq;
    logic              fr;
    logic [31:0]       res;
    logic [47:0]       ff;
    logic              fneg;
    logic [23:0]       m24;
    logic [4:0]        lz;
    logic signed [8:0] ex;
  } s1_t;

  typedef struct packed {
    logic             sq;
    logic             fr;
    logic [31:0]      res;
    logic [48:0]      g;
    logic [5:0]       glz;
    logic [RAD_W-1:0] rad;
    logic [7:0]       sexp;
  } s2_t;

  typedef struct packed {
    logic              sq;
    logic [31:0]       res;
    logic [RAD_W-1:0]  rad;
    logic [ROOT_W-1:0] root;
    logic [REM_W-1:0]  rem;
    logic [7:0]        sexp;
  } pipe_t;

  logic            adv;
  logic [NSTG-1:0] v_q;
  s1_t             s1_d, s1_q;
  s2_t             s2_d, s2_q;
  pipe_t           p_d [0:SQRT_STEPS];
  pipe_t           p_q [0:SQRT_STEPS];
  logic [31:0]     out_d, out_q;

  logic [ROOT_W-1:0] step_root [0:SQRT_STEPS-1];
  logic [REM_W-1:0]  step_rem  [0:SQRT_STEPS-1];

  assign adv           = !v_q[NSTG-1] || out_ready_i;
  assign in_ready_o    = adv;
  assign out_valid_o   = v_q[NSTG-1];
  assign result_bits_o = out_q;

  // stage 1: decode, simple ops, special cases
  logic [7:0]  a_e;
  logic [5:0]  fsh;
  logic [70:0] fwide;
  logic [23:0] m24;
  logic [4:0]  lz24;

  always_comb begin
    a_e   = operand_a_i[30:23];
    fsh   = 6'(a_e - 8'd102);
    fwide = {47'd0, 1'b1, operand_a_i[22:0]} << fsh;
    m24   = {a_e != 8'd0, operand_a_i[22:0]};
    lz24  = lzc24(m24);
    s1_d      = '0;
    s1_d.ff   = fwide[47:0];
    s1_d.fneg = operand_a_i[31];
    s1_d.m24  = m24;
    s1_d.lz   = lz24;
    s1_d.ex   = (a_e == 8'd0) ? (-9'sd126 - $signed({4'd0, lz24}))
                              : ($signed({1'b0, a_e}) - 9'sd127);
    unique case (mode_i) inside
      OP_ABS:  s1_d.res = {1'b0, operand_a_i[30:0]};
      OP_SIGN: s1_d.res = sign_of(operand_a_i);
      OP_FLOOR, OP_CEIL, OP_ROUND, OP_TRUNC: begin
        s1_d.res = round_integral(operand_a_i, op_e'(mode_i));
      end
      OP_FRACT: begin
        if (a_e == 8'hFF) begin
          s1_d.res = is_nan(operand_a_i) ? (operand_a_i | QUIET_BIT) : GEN_NAN;
        end else if ((operand_a_i[30:0] == 31'd0) || (a_e >= 8'd150)) begin
          s1_d.res = ZERO_BITS;
        end else if (!operand_a_i[31] && (a_e < 8'd127)) begin
          s1_d.res = operand_a_i;
        end else if (operand_a_i[31] && (a_e < 8'd102)) begin
          s1_d.res = ONE_BITS;
        end else if (fwide[47:0] == 48'd0) begin
          s1_d.res = ZERO_BITS;
        end else begin
          s1_d.fr = 1'b1;
        end
      end
      OP_SQRT: begin
        if (is_nan(operand_a_i)) begin
          s1_d.res = operand_a_i | QUIET_BIT;
        end else if (operand_a_i[30:0] == 31'd0) begin
          s1_d.res = operand_a_i;
        end else if (operand_a_i[31]) begin
          s1_d.res = GEN_NAN;
        end else if (a_e == 8'hFF) begin
          s1_d.res = operand_a_i;
        end else begin
          s1_d.sq = 1'b1;
        end
      end
      OP_MIN:  s1_d.res = flt_lt(operand_b_i, operand_a_i) ? operand_b_i : operand_a_i;
      OP_MAX:  s1_d.res = flt_lt(operand_a_i, operand_b_i) ? operand_b_i : operand_a_i;
      default: s1_d.res = ZERO_BITS;
    endcase
  end

  // stage 2: fract complement and lzc, sqrt normalize and radicand
  logic [23:0]       mn;
  logic signed [8:0] exa;
  logic signed [8:0] exh;
  logic [24:0]       m25;
  logic [48:0]       g;

  always_comb begin
    g   = s1_q.fneg ? (49'h1_0000_0000_0000 - {1'b0, s1_q.ff}) : {1'b0, s1_q.ff};
    mn  = s1_q.m24 << s1_q.lz;
    if (s1_q.ex[0]) begin
      m25 = {mn, 1'b0};
      exa = s1_q.ex - 9'sd1;
    end else begin
      m25 = {1'b0, mn};
      exa = s1_q.ex;
    end
    exh       = (exa >>> 1) + 9'sd127;
    s2_d.sq   = s1_q.sq;
    s2_d.fr   = s1_q.fr;
    s2_d.res  = s1_q.res;
    s2_d.g    = g;
    s2_d.glz  = lzc49(g);
    s2_d.rad  = {m25, 25'd0};
    s2_d.sexp = exh[7:0];
  end

  // stage 3: fract normalize and round
  logic [48:0] norm;
  logic [24:0] fsum;
  logic        frnd;
  logic [7:0]  fexp;

  always_comb begin
    norm = s2_q.g << s2_q.glz;
    frnd = norm[24] && ((norm[23:0] != 24'd0) || norm[25]);
    fsum = {1'b0, norm[48:25]} + {24'd0, frnd};
    fexp = 8'd127 - {2'd0, s2_q.glz} + {7'd0, fsum[24]};
    p_d[0].sq   = s2_q.sq;
    p_d[0].res  = s2_q.fr ? {1'b0, fexp, fsum[24] ? fsum[23:1] : fsum[22:0]} : s2_q.res;
    p_d[0].rad  = s2_q.rad;
    p_d[0].root = '0;
    p_d[0].rem  = '0;
    p_d[0].sexp = s2_q.sexp;
  end

  // square-root iterations
  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    fsu_sqrt_step u_step (
      .pair_i (p_q[k].rad[RAD_W-1:RAD_W-2]),
      .root_i (p_q[k].root),
      .rem_i  (p_q[k].rem),
      .root_o (step_root[k]),
      .rem_o  (step_rem[k])
    );
    always_comb begin
      p_d[k+1]      = p_q[k];
      p_d[k+1].rad  = {p_q[k].rad[RAD_W-3:0], 2'b00};
      p_d[k+1].root = step_root[k];
      p_d[k+1].rem  = step_rem[k];
    end
  end

  // final sqrt rounding
  logic        sg;
  logic [24:0] rsum;
  logic [7:0]  rexp;

  always_comb begin
    sg   = p_q[SQRT_STEPS].root[0] &&
           ((p_q[SQRT_STEPS].rem != '0) || p_q[SQRT_STEPS].root[1]);
    rsum = {1'b0, p_q[SQRT_STEPS].root[ROOT_W-1:1]} + {24'd0, sg};
    rexp = p_q[SQRT_STEPS].sexp + {7'd0, rsum[24]};
    if (p_q[SQRT_STEPS].sq) begin
      out_d = {1'b0, rexp, rsum[24] ? rsum[23:1] : rsum[22:0]};
    end else begin
      out_d = p_q[SQRT_STEPS].res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv) begin
      v_q <= {v_q[NSTG-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_q  <= s1_d;
      s2_q  <= s2_d;
      out_q <= out_d;
      for (int i = 0; i <= SQRT_STEPS; i++) begin
        p_q[i] <= p_d[i];
      end
    end
  end

endmodule

[sv/fsu_checker.sv]
// ----------------------------------------------------------------------------
// fsu_checker
// Port-level checks of the scalar float unit, bound to the top level.
// ----------------------------------------------------------------------------
module fsu_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [31:0] result_bits_o
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(result_bits_o))
    else $error("stalled result changed");

  // input side follows output backpressure
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o == (!out_valid_o || out_ready_i))
    else $error("in_ready_o does not follow output stall");

  // a new result appears only on a cycle the pipeline moved
  a_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_ready_o))
    else $error("result appeared while pipeline stalled");

endmodule

bind float32_scalar_unit fsu_checker u_fsu_checker (.*);
